[src/rme_pkg.sv]
package rme_pkg;

  localparam int REG_COUNT  = 256;
  localparam int VALUE_BITS = 32;
  localparam int CODE_DEPTH = 256;

  localparam int REG_IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int PC_W      = (CODE_DEPTH > 1) ? $clog2(CODE_DEPTH) : 1;

  // ceil(2^16 / d): quotient estimate is exact for any 8-bit dividend, d up to 256
  localparam int REG_RECIP  = (65536 + REG_COUNT - 1) / REG_COUNT;
  localparam int CODE_RECIP = (65536 + CODE_DEPTH - 1) / CODE_DEPTH;

  typedef logic [REG_IDX_W-1:0]  reg_idx_t;
  typedef logic [PC_W-1:0]       pc_t;
  typedef logic [VALUE_BITS-1:0] value_t;

  localparam logic CMD_EXEC    = 1'b0;
  localparam logic CMD_INSPECT = 1'b1;

  localparam logic [3:0] OP_NOP = 4'd0;
  localparam logic [3:0] OP_SET = 4'd1;
  localparam logic [3:0] OP_MOV = 4'd2;
  localparam logic [3:0] OP_ADD = 4'd3;
  localparam logic [3:0] OP_SUB = 4'd4;
  localparam logic [3:0] OP_MUL = 4'd5;
  localparam logic [3:0] OP_HLT = 4'd6;
  localparam logic [3:0] OP_JMP = 4'd7;
  localparam logic [3:0] OP_IFZ = 4'd8;
  localparam logic [3:0] OP_IFP = 4'd9;
  localparam logic [3:0] OP_IFN = 4'd10;
  localparam logic [3:0] OP_PRI = 4'd11;
  localparam logic [3:0] OP_PRB = 4'd12;

  localparam logic [1:0] PK_NONE = 2'd0;
  localparam logic [1:0] PK_INT  = 2'd1;
  localparam logic [1:0] PK_BOOL = 2'd2;

  // 8-bit remainder by a constant: reciprocal multiply for the quotient, then
  // one multiply-subtract
  function automatic logic [7:0] mod_const(logic [7:0] a, int unsigned d,
                                           int unsigned recip);
    logic [24:0] prod;
    logic [7:0]  quot;
    logic [15:0] back;
    prod = 25'(a) * 25'(recip);
    quot = prod[23:16];
    back = 16'(quot) * 16'(d);
    return 8'(16'(a) - back);
  endfunction

  function automatic reg_idx_t reg_index(logic [7:0] a);
    return REG_IDX_W'(mod_const(a, REG_COUNT, REG_RECIP));
  endfunction

  function automatic pc_t code_addr(logic [7:0] a);
    return PC_W'(mod_const(a, CODE_DEPTH, CODE_RECIP));
  endfunction

  // sign-extend a register value, keep the low 32 bits
  function automatic logic [31:0] report32(value_t v);
    logic signed [63:0] ext;
    ext = 64'(signed'(v));
    return ext[31:0];
  endfunction

endpackage

[src/rme_ram.sv]
module rme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/register_machine_executor_core.sv]
// Executes one register-machine instruction, or one register inspect, per input
// transfer and returns exactly one result per transfer. Throughput is one item
// per clock while out_stall does not hold the output: the register file (three
// copies, one per operand port) is read at the transfer edge, stage 1 computes
// and writes back when its item advances, and the result register presents
// it. A write that lands in the same edge as the following read is
// forwarded. The register file needs no clearing pass after reset: a per-register
// valid bit makes unwritten registers read as zero, so items are taken from the
// first cycle out of reset. Once a halt or an undefined opcode stops the machine,
// execute items report the frozen program counter with running low until reset;
// inspect items keep working.
module register_machine_executor_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_command,
  input  logic [3:0]          in_opcode,
  input  logic [7:0]          in_first_arg,
  input  logic [7:0]          in_second_arg,
  input  logic [7:0]          in_third_arg,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_next_pc,
  output logic                out_running,
  output logic [1:0]          out_print_kind,
  output logic signed [31:0]  out_print_value,
  output logic                out_fault,
  output logic signed [31:0]  out_inspected_value,
  output logic                out_inspected_touched
);
  import rme_pkg::*;

  logic     accept;
  logic     s1_adv;
  reg_idx_t rd_a1, rd_a2, rd_a3;

  // stage 1: decoded item, RAM data arrives alongside
  logic       s1_valid_r;
  logic       s1_cmd_r;
  logic [3:0] s1_op_r;
  logic [7:0] s1_first_r;
  logic [7:0] s1_second_r;
  reg_idx_t   s1_a1_r, s1_a2_r, s1_a3_r;
  value_t     ram1_q, ram2_q, ram3_q;

  // write that coincided with the stage-1 item's RAM read
  logic     byp_en_r;
  reg_idx_t byp_addr_r;
  value_t   byp_data_r;

  // architectural state
  logic [REG_COUNT-1:0] valid_r;
  logic [REG_COUNT-1:0] touched_r, touched_nxt;
  pc_t                  pc_r, pc_nxt;
  logic                 run_r, run_nxt;

  logic     wr_en;
  value_t   wr_data;
  value_t   x1, x2, x3;
  pc_t      pc_plus;
  logic [1:0]  kind;
  logic [31:0] pval;
  logic        flt;
  logic [31:0] ival;
  logic        itouch;

  logic        out_valid_r;
  logic [7:0]  out_pc_r;
  logic        out_run_r;
  logic [1:0]  out_kind_r;
  logic [31:0] out_pval_r;
  logic        out_fault_r;
  logic [31:0] out_ival_r;
  logic        out_itouch_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;

  assign rd_a1 = reg_index(in_first_arg);
  assign rd_a2 = reg_index(in_second_arg);
  assign rd_a3 = reg_index(in_third_arg);

  rme_ram #(.WIDTH(VALUE_BITS), .DEPTH(REG_COUNT)) u_rf1 (
    .clk(clk), .we(wr_en), .waddr(s1_a1_r), .wdata(wr_data),
    .re(accept), .raddr(rd_a1), .rdata(ram1_q)
  );

  rme_ram #(.WIDTH(VALUE_BITS), .DEPTH(REG_COUNT)) u_rf2 (
    .clk(clk), .we(wr_en), .waddr(s1_a1_r), .wdata(wr_data),
    .re(accept), .raddr(rd_a2), .rdata(ram2_q)
  );

  rme_ram #(.WIDTH(VALUE_BITS), .DEPTH(REG_COUNT)) u_rf3 (
    .clk(clk), .we(wr_en), .waddr(s1_a1_r), .wdata(wr_data),
    .re(accept), .raddr(rd_a3), .rdata(ram3_q)
  );

  // operand select: forwarded write, else RAM if ever written, else zero
  always_comb begin
    if (byp_en_r && byp_addr_r == s1_a1_r) begin
      x1 = byp_data_r;
    end else begin
      x1 = valid_r[s1_a1_r] ? ram1_q : '0;
    end
    if (byp_en_r && byp_addr_r == s1_a2_r) begin
      x2 = byp_data_r;
    end else begin
      x2 = valid_r[s1_a2_r] ? ram2_q : '0;
    end
    if (byp_en_r && byp_addr_r == s1_a3_r) begin
      x3 = byp_data_r;
    end else begin
      x3 = valid_r[s1_a3_r] ? ram3_q : '0;
    end
  end

  assign pc_plus = (pc_r == PC_W'(CODE_DEPTH - 1)) ? '0 : pc_r + PC_W'(1);

  always_comb begin
    touched_nxt = touched_r;
    pc_nxt      = pc_r;
    run_nxt     = run_r;
    wr_en       = 1'b0;
    wr_data     = x2;
    kind        = PK_NONE;
    pval        = '0;
    flt         = 1'b0;
    ival        = '0;
    itouch      = 1'b0;
    if (s1_valid_r) begin
      if (s1_cmd_r == CMD_INSPECT) begin
        ival   = report32(x1);
        itouch = touched_r[s1_a1_r];
      end else if (run_r) begin
        case (s1_op_r)
          OP_NOP: begin
            pc_nxt = pc_plus;
          end
          OP_SET: begin
            wr_en                = 1'b1;
            wr_data              = VALUE_BITS'(s1_second_r);
            touched_nxt[s1_a1_r] = 1'b1;
            pc_nxt               = pc_plus;
          end
          OP_MOV, OP_ADD, OP_SUB, OP_MUL: begin
            wr_en = 1'b1;
            case (s1_op_r)
              OP_ADD:  wr_data = x2 + x3;
              OP_SUB:  wr_data = x2 - x3;
              OP_MUL:  wr_data = VALUE_BITS'(x2 * x3);
              default: wr_data = x2;
            endcase
            touched_nxt[s1_a1_r] = 1'b1;
            touched_nxt[s1_a2_r] = 1'b1;
            if (s1_op_r != OP_MOV) begin
              touched_nxt[s1_a3_r] = 1'b1;
            end
            pc_nxt = pc_plus;
          end
          OP_HLT: begin
            run_nxt = 1'b0;
          end
          OP_JMP: begin
            pc_nxt = code_addr(s1_first_r);
          end
          OP_IFZ, OP_IFP, OP_IFN: begin
            touched_nxt[s1_a1_r] = 1'b1;
            if ((s1_op_r == OP_IFZ && x1 == '0) ||
                (s1_op_r == OP_IFP && !x1[VALUE_BITS-1]) ||
                (s1_op_r == OP_IFN && x1[VALUE_BITS-1])) begin
              pc_nxt = code_addr(s1_second_r);
            end else begin
              pc_nxt = pc_plus;
            end
          end
          OP_PRI: begin
            kind                 = PK_INT;
            pval                 = report32(x1);
            touched_nxt[s1_a1_r] = 1'b1;
            pc_nxt               = pc_plus;
          end
          OP_PRB: begin
            kind                 = PK_BOOL;
            pval                 = (x1 != '0) ? 32'd1 : 32'd0;
            touched_nxt[s1_a1_r] = 1'b1;
            pc_nxt               = pc_plus;
          end
          default: begin
            flt     = 1'b1;
            run_nxt = 1'b0;
          end
        endcase
      end
    end
    // state moves only when the item leaves stage 1
    if (!s1_adv) begin
      touched_nxt = touched_r;
      pc_nxt      = pc_r;
      run_nxt     = run_r;
      wr_en       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      byp_en_r   <= 1'b0;
      valid_r    <= '0;
      touched_r  <= '0;
      pc_r       <= '0;
      run_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
        byp_en_r   <= wr_en;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (wr_en) begin
        valid_r[s1_a1_r] <= 1'b1;
      end
      touched_r <= touched_nxt;
      pc_r      <= pc_nxt;
      run_r     <= run_nxt;
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r    <= in_command;
      s1_op_r     <= in_opcode;
      s1_first_r  <= in_first_arg;
      s1_second_r <= in_second_arg;
      s1_a1_r     <= rd_a1;
      s1_a2_r     <= rd_a2;
      s1_a3_r     <= rd_a3;
      byp_addr_r  <= s1_a1_r;
      byp_data_r  <= wr_data;
    end
    if (s1_adv) begin
      out_pc_r     <= 8'(pc_nxt);
      out_run_r    <= run_nxt;
      out_kind_r   <= kind;
      out_pval_r   <= pval;
      out_fault_r  <= flt;
      out_ival_r   <= ival;
      out_itouch_r <= itouch;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_next_pc           = out_pc_r;
  assign out_running           = out_run_r;
  assign out_print_kind        = out_kind_r;
  assign out_print_value       = signed'(out_pval_r);
  assign out_fault             = out_fault_r;
  assign out_inspected_value   = signed'(out_ival_r);
  assign out_inspected_touched = out_itouch_r;

endmodule
